// File: src/tts_pkg.sv
// Shared types and constants for the trade tick time window statistics block.
// Used by the RTL and the testbench. No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

   localparam int RING_DEPTH_DEF = 1024;

   localparam int TIME_W = 48;
   localparam int VOL_W  = 24;
   localparam int SUM_W  = 34;
   localparam int CNT_W  = 11;
   localparam int CFG_W  = 32;
   localparam int SV_W   = VOL_W + 1;

   localparam logic [CFG_W-1:0] SPAN_RESET = CFG_W'(5000000);
   localparam logic [CFG_W-1:0] LAG_RESET  = CFG_W'(100000);

   typedef enum logic {
      CSR_SPAN = 1'b0,
      CSR_LAG  = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_EVENT = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic {
      SIDE_BUY  = 1'b0,
      SIDE_SELL = 1'b1
   } side_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUNDS,
      ST_ADM_RD,
      ST_ADM_CHK,
      ST_EXP_RD,
      ST_EXP_CHK,
      ST_INSERT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic load_bounds;
      logic rd_expire;
      logic admit_step;
      logic expire_step;
      logic write_tick;
      logic set_drop;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic admit_ok;
      logic admit_empty;
      logic admit_stop;
      logic expire_empty;
      logic expire_stop;
      logic full;
   } status_type;

endpackage

// File: src/tts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tts_ctrl.sv
// Controller state machine that sequences the admit, expire and insert steps.
// Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_ctrl
   import tts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               pass_in       = 1'b0;
               state_in      = ST_BOUNDS;
            end
         end
         ST_BOUNDS: begin
            cmd.load_bounds = 1'b1;
            state_in        = ST_ADM_RD;
         end
         ST_ADM_RD: begin
            if (!status.admit_ok || status.admit_empty) begin
               state_in = ST_EXP_RD;
            end else begin
               state_in = ST_ADM_CHK;
            end
         end
         ST_ADM_CHK: begin
            if (status.admit_stop) begin
               state_in = ST_EXP_RD;
            end else begin
               cmd.admit_step = 1'b1;
               state_in       = ST_ADM_RD;
            end
         end
         ST_EXP_RD: begin
            cmd.rd_expire = 1'b1;
            if (status.expire_empty) begin
               state_in = (!pass_ff && status.is_tick) ? ST_INSERT : ST_DONE;
            end else begin
               state_in = ST_EXP_CHK;
            end
         end
         ST_EXP_CHK: begin
            cmd.rd_expire = 1'b1;
            if (status.expire_stop) begin
               state_in = (!pass_ff && status.is_tick) ? ST_INSERT : ST_DONE;
            end else begin
               cmd.expire_step = 1'b1;
               state_in        = ST_EXP_RD;
            end
         end
         ST_INSERT: begin
            if (status.full) begin
               cmd.set_drop = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.write_tick = 1'b1;
               pass_in        = 1'b1;
               state_in       = ST_ADM_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/tts_dpath.sv
// Datapath: configuration registers, ring pointers, window bounds, running sums
// and the two tick stores. Depends on tts_pkg and tts_ram.
`timescale 1ns / 1ps

module tts_dpath
   import tts_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              req_operation,
   input  logic [TIME_W-1:0] req_timestamp_us,
   input  logic              req_side,
   input  logic [VOL_W-1:0]  req_volume,
   output logic [SUM_W-1:0]  rsp_buy_volume,
   output logic [SUM_W-1:0]  rsp_sell_volume,
   output logic [CNT_W-1:0]  rsp_buy_ticks,
   output logic [CNT_W-1:0]  rsp_sell_ticks,
   output logic              rsp_dropped,
   input  cmd_type           cmd,
   output status_type        status
);

   localparam int PTR_W  = $clog2(2 * RING_DEPTH);
   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(RING_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * RING_DEPTH - 1);
   localparam logic [PTR_W:0] PTR_MOD = (PTR_W + 1)'(2 * RING_DEPTH);

   function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] s;
      s = (p >= DEPTH_P) ? p - DEPTH_P : p;
      return s[SLOT_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   logic [CFG_W-1:0]  span_ff, span_in;
   logic [CFG_W-1:0]  lag_ff, lag_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  adm_ptr_ff, adm_ptr_in;
   logic [PTR_W-1:0]  exp_ptr_ff, exp_ptr_in;
   logic [SUM_W-1:0]  buy_sum_ff, buy_sum_in;
   logic [SUM_W-1:0]  sell_sum_ff, sell_sum_in;
   logic [CNT_W-1:0]  buy_cnt_ff, buy_cnt_in;
   logic [CNT_W-1:0]  sell_cnt_ff, sell_cnt_in;
   logic [TIME_W-1:0] now_ff;
   logic              op_ff;
   logic              side_ff;
   logic [VOL_W-1:0]  vol_ff;
   logic [TIME_W-1:0] upper_ff;
   logic [TIME_W-1:0] lower_ff;
   logic              admit_ok_ff;
   logic              dropped_ff, dropped_in;
   logic [SUM_W-1:0]  rsp_buy_volume_ff;
   logic [SUM_W-1:0]  rsp_sell_volume_ff;
   logic [CNT_W-1:0]  rsp_buy_ticks_ff;
   logic [CNT_W-1:0]  rsp_sell_ticks_ff;
   logic              rsp_dropped_ff;

   logic [TIME_W-1:0] span_ext;
   logic [TIME_W-1:0] lag_ext;
   logic [SLOT_W-1:0] rd_slot;
   logic [TIME_W-1:0] rd_time;
   logic [SV_W-1:0]   rd_sv;
   logic [SUM_W-1:0]  rd_vol;
   logic [PTR_W:0]    occupancy;

   assign span_ext = TIME_W'(span_ff);
   assign lag_ext  = TIME_W'(lag_ff);
   assign rd_slot  = cmd.rd_expire ? slot_of(exp_ptr_ff) : slot_of(adm_ptr_ff);
   assign rd_vol   = SUM_W'(rd_sv[VOL_W-1:0]);

   tts_ram #(
      .WIDTH(TIME_W),
      .DEPTH(RING_DEPTH)
   ) u_time_ram (
      .clock  (clock),
      .wr_en  (cmd.write_tick),
      .wr_addr(slot_of(wr_ptr_ff)),
      .wr_data(now_ff),
      .rd_addr(rd_slot),
      .rd_data(rd_time)
   );

   tts_ram #(
      .WIDTH(SV_W),
      .DEPTH(RING_DEPTH)
   ) u_sv_ram (
      .clock  (clock),
      .wr_en  (cmd.write_tick),
      .wr_addr(slot_of(wr_ptr_ff)),
      .wr_data({side_ff, vol_ff}),
      .rd_addr(rd_slot),
      .rd_data(rd_sv)
   );

   always_comb begin
      if (wr_ptr_ff >= exp_ptr_ff) begin
         occupancy = {1'b0, wr_ptr_ff} - {1'b0, exp_ptr_ff};
      end else begin
         occupancy = {1'b0, wr_ptr_ff} + PTR_MOD - {1'b0, exp_ptr_ff};
      end
   end

   always_comb begin
      status.is_tick      = op_ff;
      status.admit_ok     = admit_ok_ff;
      status.admit_empty  = (adm_ptr_ff == wr_ptr_ff);
      status.admit_stop   = (rd_time > upper_ff);
      status.expire_empty = (exp_ptr_ff == adm_ptr_ff);
      status.expire_stop  = (rd_time >= lower_ff);
      status.full         = (occupancy >= (PTR_W + 1)'(RING_DEPTH));
   end

   always_comb begin
      span_in = span_ff;
      lag_in  = lag_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPAN: span_in = csr_wdata;
            CSR_LAG:  lag_in  = csr_wdata;
            default:  span_in = span_ff;
         endcase
      end
   end

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      adm_ptr_in  = adm_ptr_ff;
      exp_ptr_in  = exp_ptr_ff;
      buy_sum_in  = buy_sum_ff;
      sell_sum_in = sell_sum_ff;
      buy_cnt_in  = buy_cnt_ff;
      sell_cnt_in = sell_cnt_ff;
      dropped_in  = dropped_ff;
      if (cmd.load_item) begin
         dropped_in = 1'b0;
      end
      if (cmd.set_drop) begin
         dropped_in = 1'b1;
      end
      if (cmd.write_tick) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end
      if (cmd.admit_step) begin
         adm_ptr_in = next_ptr(adm_ptr_ff);
         if (rd_sv[VOL_W]) begin
            sell_sum_in = sell_sum_ff + rd_vol;
            sell_cnt_in = sell_cnt_ff + CNT_W'(1);
         end else begin
            buy_sum_in = buy_sum_ff + rd_vol;
            buy_cnt_in = buy_cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.expire_step) begin
         exp_ptr_in = next_ptr(exp_ptr_ff);
         if (rd_sv[VOL_W]) begin
            sell_sum_in = sell_sum_ff - rd_vol;
            sell_cnt_in = sell_cnt_ff - CNT_W'(1);
         end else begin
            buy_sum_in = buy_sum_ff - rd_vol;
            buy_cnt_in = buy_cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff     <= SPAN_RESET;
         lag_ff      <= LAG_RESET;
         wr_ptr_ff   <= '0;
         adm_ptr_ff  <= '0;
         exp_ptr_ff  <= '0;
         buy_sum_ff  <= '0;
         sell_sum_ff <= '0;
         buy_cnt_ff  <= '0;
         sell_cnt_ff <= '0;
         now_ff      <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         span_ff     <= span_in;
         lag_ff      <= lag_in;
         wr_ptr_ff   <= wr_ptr_in;
         adm_ptr_ff  <= adm_ptr_in;
         exp_ptr_ff  <= exp_ptr_in;
         buy_sum_ff  <= buy_sum_in;
         sell_sum_ff <= sell_sum_in;
         buy_cnt_ff  <= buy_cnt_in;
         sell_cnt_ff <= sell_cnt_in;
         dropped_ff  <= dropped_in;
         if (cmd.load_item) begin
            now_ff <= req_timestamp_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_operation;
         side_ff <= req_side;
         vol_ff  <= req_volume;
      end
      if (cmd.load_bounds) begin
         admit_ok_ff <= (now_ff >= lag_ext);
         upper_ff    <= now_ff - lag_ext;
         lower_ff    <= (now_ff >= span_ext) ? now_ff - span_ext : '0;
      end
      if (cmd.load_rsp) begin
         rsp_buy_volume_ff  <= buy_sum_ff;
         rsp_sell_volume_ff <= sell_sum_ff;
         rsp_buy_ticks_ff   <= buy_cnt_ff;
         rsp_sell_ticks_ff  <= sell_cnt_ff;
         rsp_dropped_ff     <= dropped_ff;
      end
   end

   assign rsp_buy_volume  = rsp_buy_volume_ff;
   assign rsp_sell_volume = rsp_sell_volume_ff;
   assign rsp_buy_ticks   = rsp_buy_ticks_ff;
   assign rsp_sell_ticks  = rsp_sell_ticks_ff;
   assign rsp_dropped     = rsp_dropped_ff;

endmodule

// File: src/trade_tick_time_window_stats_top.sv
// A stored tick takes longer to give its result than a dropped tick, and a dropped tick longer
// than a non-tick event; each entry admitted or expired, and an entry that ends a walk, adds
// to this, as one ring read port serves every step. A result still waiting to be taken delays
// the next load. The next transaction is accepted in the cycle after the result is loaded.
// Reset is synchronous: pointers, sums, counts, time and window registers are cleared or set
// to their defaults at once; the ring contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module trade_tick_time_window_stats_top
   import tts_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [TIME_W-1:0] req_timestamp_us,
   input  logic              req_side,
   input  logic [VOL_W-1:0]  req_volume,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SUM_W-1:0]  rsp_buy_volume,
   output logic [SUM_W-1:0]  rsp_sell_volume,
   output logic [CNT_W-1:0]  rsp_buy_ticks,
   output logic [CNT_W-1:0]  rsp_sell_ticks,
   output logic              rsp_dropped
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   tts_dpath #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_operation   (req_operation),
      .req_timestamp_us(req_timestamp_us),
      .req_side        (req_side),
      .req_volume      (req_volume),
      .rsp_buy_volume  (rsp_buy_volume),
      .rsp_sell_volume (rsp_sell_volume),
      .rsp_buy_ticks   (rsp_buy_ticks),
      .rsp_sell_ticks  (rsp_sell_ticks),
      .rsp_dropped     (rsp_dropped),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// File: dv/tts_window_checker.sv
// Checker for the trade tick time window statistics block: watches all three channels,
// keeps its own copy of the ring, pointers, sums and window registers, and compares results.
// Depends on tts_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module tts_window_checker
   import tts_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_operation,
   input  logic [TIME_W-1:0] req_timestamp_us,
   input  logic              req_side,
   input  logic [VOL_W-1:0]  req_volume,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [SUM_W-1:0]  rsp_buy_volume,
   input  logic [SUM_W-1:0]  rsp_sell_volume,
   input  logic [CNT_W-1:0]  rsp_buy_ticks,
   input  logic [CNT_W-1:0]  rsp_sell_ticks,
   input  logic              rsp_dropped,
   output int                fail_count,
   output int                pending_count
);

   localparam int PTR_MOD = 2 * RING_DEPTH;

   typedef struct {
      logic [SUM_W-1:0] buy_volume;
      logic [SUM_W-1:0] sell_volume;
      logic [CNT_W-1:0] buy_ticks;
      logic [CNT_W-1:0] sell_ticks;
      logic             dropped;
   } window_stats_type;

   window_stats_type  expected_stats[$];

   logic [CFG_W-1:0]  span_us;
   logic [CFG_W-1:0]  lag_us;
   logic [TIME_W-1:0] ring_time [RING_DEPTH];
   logic              ring_side [RING_DEPTH];
   logic [VOL_W-1:0]  ring_volume [RING_DEPTH];
   int                wr_ptr;
   int                admit_ptr;
   int                expire_ptr;
   logic [SUM_W-1:0]  buy_sum;
   logic [SUM_W-1:0]  sell_sum;
   logic [CNT_W-1:0]  buy_count;
   logic [CNT_W-1:0]  sell_count;
   logic [TIME_W-1:0] now_us;

   task automatic walk_window();
      logic [TIME_W-1:0] lower;
      logic [TIME_W-1:0] upper;
      int                s;
      lower = (now_us >= TIME_W'(span_us)) ? now_us - TIME_W'(span_us) : '0;
      if (now_us >= TIME_W'(lag_us)) begin
         upper = now_us - TIME_W'(lag_us);
         while (admit_ptr != wr_ptr && ring_time[admit_ptr % RING_DEPTH] <= upper) begin
            s = admit_ptr % RING_DEPTH;
            if (ring_side[s] == SIDE_SELL) begin
               sell_sum += SUM_W'(ring_volume[s]);
               sell_count++;
            end else begin
               buy_sum += SUM_W'(ring_volume[s]);
               buy_count++;
            end
            admit_ptr = (admit_ptr + 1) % PTR_MOD;
         end
      end
      while (expire_ptr != admit_ptr && ring_time[expire_ptr % RING_DEPTH] < lower) begin
         s = expire_ptr % RING_DEPTH;
         if (ring_side[s] == SIDE_SELL) begin
            sell_sum -= SUM_W'(ring_volume[s]);
            sell_count--;
         end else begin
            buy_sum -= SUM_W'(ring_volume[s]);
            buy_count--;
         end
         expire_ptr = (expire_ptr + 1) % PTR_MOD;
      end
   endtask

   task automatic predict_window_stats(input logic op, input logic [TIME_W-1:0] ts,
                                       input logic side, input logic [VOL_W-1:0] vol);
      window_stats_type stats;
      int               occupancy;
      int               s;
      stats.dropped = 1'b0;
      now_us = ts;
      walk_window();
      if (op == OP_TICK) begin
         occupancy = (wr_ptr + PTR_MOD - expire_ptr) % PTR_MOD;
         if (occupancy >= RING_DEPTH) begin
            stats.dropped = 1'b1;
         end else begin
            s = wr_ptr % RING_DEPTH;
            ring_time[s] = ts;
            ring_side[s] = side;
            ring_volume[s] = vol;
            wr_ptr = (wr_ptr + 1) % PTR_MOD;
            walk_window();
         end
      end
      stats.buy_volume = buy_sum;
      stats.sell_volume = sell_sum;
      stats.buy_ticks = buy_count;
      stats.sell_ticks = sell_count;
      expected_stats = {expected_stats, stats};
   endtask

   task automatic check_field(input string field, input logic [SUM_W-1:0] expected,
                              input logic [SUM_W-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      window_stats_type stats;
      if (reset) begin
         span_us = SPAN_RESET;
         lag_us = LAG_RESET;
         wr_ptr = 0;
         admit_ptr = 0;
         expire_ptr = 0;
         buy_sum = '0;
         sell_sum = '0;
         buy_count = '0;
         sell_count = '0;
         now_us = '0;
         expected_stats.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               $display("%0t: unexpected result transaction, expected none, actual buy_volume %0d",
                        $time, rsp_buy_volume);
               fail_count++;
            end else begin
               stats = expected_stats.pop_front();
               check_field("buy_volume", stats.buy_volume, rsp_buy_volume);
               check_field("sell_volume", stats.sell_volume, rsp_sell_volume);
               check_field("buy_ticks", SUM_W'(stats.buy_ticks), SUM_W'(rsp_buy_ticks));
               check_field("sell_ticks", SUM_W'(stats.sell_ticks), SUM_W'(rsp_sell_ticks));
               check_field("dropped", SUM_W'(stats.dropped), SUM_W'(rsp_dropped));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SPAN) begin
               span_us = csr_wdata;
            end else begin
               lag_us = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            predict_window_stats(req_operation, req_timestamp_us, req_side, req_volume);
         end
      end
      pending_count = expected_stats.size();
   end

endmodule

// File: dv/tb_top.sv
// Top of the testbench for the trade tick time window statistics block: clock, reset,
// directed and random event stimulus, window register writes, and the final verdict.
// Depends on tts_pkg, the block's top level and the tts_window_checker module.
`timescale 1ns / 1ps

module tb_top
   import tts_pkg::*;
();

   localparam logic [CFG_W-1:0]  CFG_MAX   = '1;
   localparam logic [TIME_W-1:0] TIME_MAX  = '1;
   localparam logic [VOL_W-1:0]  VOL_MAX   = '1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_SPAN;
   logic [CFG_W-1:0]  csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = OP_EVENT;
   logic [TIME_W-1:0] req_timestamp_us = '0;
   logic              req_side = SIDE_BUY;
   logic [VOL_W-1:0]  req_volume = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [SUM_W-1:0]  rsp_buy_volume;
   logic [SUM_W-1:0]  rsp_sell_volume;
   logic [CNT_W-1:0]  rsp_buy_ticks;
   logic [CNT_W-1:0]  rsp_sell_ticks;
   logic              rsp_dropped;

   int                fail_count;
   int                pending_count;
   logic [TIME_W-1:0] event_time = '0;
   logic [TIME_W-1:0] peak_time = '0;
   int                burst_left = 0;
   int                stall_pct = 0;
   int                stall_timer = 0;

   always #10 clock = ~clock;

   trade_tick_time_window_stats_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_timestamp_us (req_timestamp_us),
      .req_side         (req_side),
      .req_volume       (req_volume),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_buy_volume   (rsp_buy_volume),
      .rsp_sell_volume  (rsp_sell_volume),
      .rsp_buy_ticks    (rsp_buy_ticks),
      .rsp_sell_ticks   (rsp_sell_ticks),
      .rsp_dropped      (rsp_dropped)
   );

   tts_window_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_timestamp_us (req_timestamp_us),
      .req_side         (req_side),
      .req_volume       (req_volume),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_buy_volume   (rsp_buy_volume),
      .rsp_sell_volume  (rsp_sell_volume),
      .rsp_buy_ticks    (rsp_buy_ticks),
      .rsp_sell_ticks   (rsp_sell_ticks),
      .rsp_dropped      (rsp_dropped),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_timer <= $urandom_range(32, 300);
         case ($urandom_range(0, 3))
            0: begin
               stall_pct <= 0;
            end
            1: begin
               stall_pct <= 25;
            end
            2: begin
               stall_pct <= 60;
            end
            default: begin
               stall_pct <= 90;
            end
         endcase
      end else begin
         stall_timer <= stall_timer - 1;
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_event(input logic op, input logic [TIME_W-1:0] ts,
                             input logic side, input logic [VOL_W-1:0] vol);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_timestamp_us <= ts;
      req_side <= side;
      req_volume <= vol;
      event_time = ts;
      if (ts > peak_time) begin
         peak_time = ts;
      end
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [CFG_W-1:0] span, input logic [CFG_W-1:0] lag);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_SPAN;
      csr_wdata <= span;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LAG;
      csr_wdata <= lag;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_window_phase(input int count, input logic [CFG_W-1:0] span,
                                   input logic [CFG_W-1:0] lag);
      int unsigned       step_max;
      longint unsigned   ts;
      int                pick;
      logic              op;
      logic [VOL_W-1:0]  vol;
      write_window(span, lag);
      step_max = span / 16 + lag / 16 + 1;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         ts = event_time;
         if (pick < 3) begin
            ts = (ts > step_max) ? ts - $urandom_range(0, step_max) : 0;
         end else if (pick < 16 && pick >= 12) begin
            ts = peak_time + span + lag + 1 + $urandom_range(0, 1000);
         end else if (pick >= 16) begin
            ts = ts + $urandom_range(0, step_max);
         end
         op = ($urandom_range(0, 99) < 75) ? OP_TICK : OP_EVENT;
         case ($urandom_range(0, 19))
            0: begin
               vol = '0;
            end
            1: begin
               vol = VOL_MAX;
            end
            default: begin
               vol = VOL_W'($urandom());
            end
         endcase
         send_event(op, TIME_W'(ts), 1'($urandom_range(0, 1)), vol);
      end
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] span;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_event(OP_EVENT, 0, SIDE_SELL, VOL_MAX);
      send_event(OP_TICK, 0, SIDE_BUY, 0);
      send_event(OP_TICK, 10, SIDE_SELL, VOL_MAX);
      send_event(OP_TICK, 50000, SIDE_BUY, VOL_MAX);
      send_event(OP_EVENT, 100000, SIDE_BUY, 0);
      send_event(OP_TICK, 100010, SIDE_SELL, 1);
      send_event(OP_EVENT, 200050, SIDE_BUY, 0);
      send_event(OP_EVENT, 5100000, SIDE_BUY, 0);
      send_event(OP_EVENT, 5200050, SIDE_BUY, 0);
      write_window(0, 0);
      send_event(OP_TICK, 6000000, SIDE_BUY, 123);
      send_event(OP_TICK, 6000000, SIDE_SELL, 7);
      send_event(OP_EVENT, 6000001, SIDE_BUY, 0);
      write_window(10, 20);
      send_event(OP_TICK, 6000100, SIDE_BUY, 5);
      send_event(OP_EVENT, 6000120, SIDE_BUY, 0);
      send_event(OP_TICK, 6000121, SIDE_SELL, 9);
      send_event(OP_EVENT, 6000200, SIDE_BUY, 0);

      run_window_phase(30, SPAN_RESET, LAG_RESET);
      run_window_phase(20, 0, 0);
      run_window_phase(20, CFG_MAX, 0);
      run_window_phase(20, 1000, 5000);
      run_window_phase(20, CFG_MAX, CFG_MAX);
      repeat (2) begin
         span = $urandom_range(0, 2000000);
         run_window_phase(20, span, $urandom_range(0, span));
      end

      // With the lag at its maximum nothing is admitted or expired, so the ring fills up.
      write_window(0, 0);
      send_event(OP_EVENT, peak_time + 1, SIDE_BUY, 0);
      write_window(CFG_MAX, CFG_MAX);
      repeat (RING_DEPTH_DEF + 4) begin
         send_event(OP_TICK, event_time + $urandom_range(0, 1), 1'($urandom_range(0, 1)),
                    VOL_W'($urandom()));
      end
      write_window(0, 0);
      send_event(OP_EVENT, peak_time + 1, SIDE_BUY, 0);

      write_window(CFG_MAX, CFG_MAX);
      send_event(OP_TICK, TIME_MAX, SIDE_BUY, VOL_MAX);
      send_event(OP_TICK, 5, SIDE_SELL, VOL_MAX);
      send_event(OP_TICK, TIME_MAX, SIDE_SELL, 1);
      write_window(0, 0);
      send_event(OP_EVENT, TIME_MAX, SIDE_BUY, 0);

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
